// ----- hw/rtl/tnps_pkg.sv -----
// ----------------------------------------------------------------------------
// tnps_pkg
// shared types and constants for the top-n pair selection block
// ----------------------------------------------------------------------------
package tnps_pkg;

    localparam int DEF_MAX_ENTRIES  = 32;
    localparam int DEF_WORD_ID_BITS = 20;

    localparam int SCORE_W = 17;
    localparam int CFG_W   = 6;
    localparam int RANK_W  = 5;
    localparam int PAIRS_W = 64;
    localparam int MAX_OUT = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd20;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // per-cell insert control
    typedef struct packed {
        logic en;      // cell lies within the insert window
        logic at_end;  // cell is the last slot of the window: free, or holding the dropped entry
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/tnps_cell.sv -----
// ----------------------------------------------------------------------------
// tnps_cell
// one slot of the sorted chain: holds a pair, compares it with the
// candidate and takes either the candidate or its upper neighbour's pair
// ----------------------------------------------------------------------------
module tnps_cell #(
    parameter int WORD_ID_BITS = tnps_pkg::DEF_WORD_ID_BITS
) (
    input  logic                         i_clk,
    input  tnps_pkg::t_cell_ctrl         i_ctrl,
    input  logic [tnps_pkg::SCORE_W-1:0] i_cand_score,
    input  logic [WORD_ID_BITS-1:0]      i_cand_first,
    input  logic [WORD_ID_BITS-1:0]      i_cand_second,
    input  logic                         i_prev_shift,
    input  logic [tnps_pkg::SCORE_W-1:0] i_prev_score,
    input  logic [WORD_ID_BITS-1:0]      i_prev_first,
    input  logic [WORD_ID_BITS-1:0]      i_prev_second,
    output logic                         o_shift,
    output logic                         o_gt,
    output logic [tnps_pkg::SCORE_W-1:0] o_score,
    output logic [WORD_ID_BITS-1:0]      o_first,
    output logic [WORD_ID_BITS-1:0]      o_second
);
    import tnps_pkg::*;

    logic [SCORE_W-1:0]      r_score;
    logic [WORD_ID_BITS-1:0] r_first;
    logic [WORD_ID_BITS-1:0] r_second;

    // strictly greater: equal scores keep the older entry above
    assign o_gt    = i_cand_score > r_score;
    assign o_shift = i_ctrl.at_end || o_gt;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en && o_shift) begin
            if (i_prev_shift) begin
                r_score  <= i_prev_score;
                r_first  <= i_prev_first;
                r_second <= i_prev_second;
            end else begin
                r_score  <= i_cand_score;
                r_first  <= i_cand_first;
                r_second <= i_cand_second;
            end
        end
    end

    assign o_score  = r_score;
    assign o_first  = r_first;
    assign o_second = r_second;

endmodule

// ----- hw/rtl/top_n_pair_selection.sv -----
// ----------------------------------------------------------------------------
// top_n_pair_selection
// keeps the highest-scoring pairs of a scored pair stream in a sorted chain
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands. tuser selects offer or readout; tdata carries
//   the two word identifiers and the Q1.16 score. An offer is absorbed by
//   the cell chain in the cycle it is accepted, so offers may follow one per
//   cycle while no readout runs. Equal identifiers are counted but not kept.
//   A readout walks the chain from the best entry down, one result per cycle
//   through the output register when m_axis does not stall: min(held, 32)
//   results, or one invalid result when the table is empty. The readout
//   transaction moves the sequencer to ST_READ, which then loads the results
//   into the output register; s_axis stays not ready until the last result
//   has been loaded.
//   m_axis tlast marks the final result of a readout, tuser the entry flag.
//   The user is to write the kept count on the cfg port only while idle; the
//   block does not enforce this. Values above the built depth act as the
//   built depth. Reset empties the table, clears the pair counter and sets
//   the kept count to 20. A stall on m_axis holds the result and, during a
//   readout, the walk; offers are still taken while the last result waits.
// ----------------------------------------------------------------------------
module top_n_pair_selection #(
    parameter int MAX_ENTRIES  = tnps_pkg::DEF_MAX_ENTRIES,
    parameter int WORD_ID_BITS = tnps_pkg::DEF_WORD_ID_BITS,
    localparam int IN_W  = ((2 * WORD_ID_BITS + tnps_pkg::SCORE_W + 7) / 8) * 8,
    localparam int OUT_W = ((tnps_pkg::RANK_W + 2 * WORD_ID_BITS + tnps_pkg::SCORE_W
                             + tnps_pkg::PAIRS_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tnps_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // first_word, second_word, score
    input  logic [IN_W-1:0]            i_s_axis_tdata,
    // action
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // rank, out_first_word, out_second_word, out_score, pairs_checked
    output logic [OUT_W-1:0]           o_m_axis_tdata,
    // entry_valid
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);
    import tnps_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int OUT_LIM = (MAX_ENTRIES < MAX_OUT) ? MAX_ENTRIES : MAX_OUT;
    localparam int WB      = WORD_ID_BITS;

    // command fields
    logic [WB-1:0]      w_in_first;
    logic [WB-1:0]      w_in_second;
    logic [SCORE_W-1:0] w_in_score;

    assign w_in_first  = i_s_axis_tdata[WB-1:0];
    assign w_in_second = i_s_axis_tdata[2*WB-1:WB];
    assign w_in_score  = i_s_axis_tdata[2*WB+SCORE_W-1:2*WB];

    // control state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]   r_count;
    logic [PAIRS_W-1:0] r_pairs;
    logic [CFG_W-1:0]   r_cfg;
    logic               r_o_tvalid;

    // output payload
    logic [RANK_W-1:0]  r_o_rank;
    logic               r_o_entry;
    logic [WB-1:0]      r_o_first;
    logic [WB-1:0]      r_o_second;
    logic [SCORE_W-1:0] r_o_score;
    logic [PAIRS_W-1:0] r_o_pairs;
    logic               r_o_last;

    logic w_accept;
    logic w_offer;
    logic w_read;
    logic w_load;
    logic w_rd_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_offer  = w_accept && (i_s_axis_tuser == ACT_OFFER);
    assign w_read   = w_accept && (i_s_axis_tuser == ACT_READ);
    assign w_load   = (r_state == ST_READ) && (!r_o_tvalid || i_m_axis_tready);

    // effective kept count
    logic [LIM_W-1:0] w_cfg_ext;
    logic [CNT_W-1:0] w_limit;
    logic             w_full;
    logic [CNT_W-1:0] w_win;
    logic             w_do_insert;
    logic [CNT_W-1:0] w_out_n;

    assign w_cfg_ext = LIM_W'(r_cfg);
    assign w_limit   = (w_cfg_ext > LIM_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(r_cfg);
    assign w_full    = r_count >= w_limit;
    // when full the lowest entry is dropped, so the window is one shorter
    assign w_win     = w_full ? (r_count - CNT_W'(1)) : r_count;
    assign w_out_n   = (r_count > CNT_W'(OUT_LIM)) ? CNT_W'(OUT_LIM) : r_count;

    // cell chain
    t_cell_ctrl         w_ctrl   [MAX_ENTRIES];
    logic               w_shift  [MAX_ENTRIES];
    logic               w_gt     [MAX_ENTRIES];
    logic [SCORE_W-1:0] w_score  [MAX_ENTRIES];
    logic [WB-1:0]      w_first  [MAX_ENTRIES];
    logic [WB-1:0]      w_second [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_tail_gt;

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
            assign w_ctrl[k].en     = w_do_insert && (CNT_W'(k) <= w_win);
            assign w_ctrl[k].at_end = (CNT_W'(k) == w_win);
            assign w_tail_gt[k]     = w_gt[k] && (CNT_W'(k + 1) == r_count);

            if (k == 0) begin : g_head
                tnps_cell #(
                    .WORD_ID_BITS(WORD_ID_BITS)
                ) u_cell (
                    .i_clk         (i_clk),
                    .i_ctrl        (w_ctrl[k]),
                    .i_cand_score  (w_in_score),
                    .i_cand_first  (w_in_first),
                    .i_cand_second (w_in_second),
                    .i_prev_shift  (1'b0),
                    .i_prev_score  (w_in_score),
                    .i_prev_first  (w_in_first),
                    .i_prev_second (w_in_second),
                    .o_shift       (w_shift[k]),
                    .o_gt          (w_gt[k]),
                    .o_score       (w_score[k]),
                    .o_first       (w_first[k]),
                    .o_second      (w_second[k])
                );
            end else begin : g_body
                tnps_cell #(
                    .WORD_ID_BITS(WORD_ID_BITS)
                ) u_cell (
                    .i_clk         (i_clk),
                    .i_ctrl        (w_ctrl[k]),
                    .i_cand_score  (w_in_score),
                    .i_cand_first  (w_in_first),
                    .i_cand_second (w_in_second),
                    .i_prev_shift  (w_shift[k-1]),
                    .i_prev_score  (w_score[k-1]),
                    .i_prev_first  (w_first[k-1]),
                    .i_prev_second (w_second[k-1]),
                    .o_shift       (w_shift[k]),
                    .o_gt          (w_gt[k]),
                    .o_score       (w_score[k]),
                    .o_first       (w_first[k]),
                    .o_second      (w_second[k])
                );
            end
        end
    endgenerate

    assign w_do_insert = w_offer && (w_in_first != w_in_second)
                      && (!w_full || ((r_count != '0) && (|w_tail_gt)));

    assign w_rd_last = (CNT_W'(r_rd_idx) + CNT_W'(1)) == w_out_n;

    // readout sequencer
    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_read) begin
                    n_state  = ST_READ;
                    n_rd_idx = '0;
                end
            end
            ST_READ: begin
                if (w_load) begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                    if (r_count == '0 || w_rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_idx   <= '0;
            r_count    <= '0;
            r_pairs    <= '0;
            r_cfg      <= CFG_RESET;
            r_o_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_offer) begin
                r_pairs <= r_pairs + PAIRS_W'(1);
            end
            if (w_do_insert && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load) begin
                r_o_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_tvalid <= 1'b0;
            end
        end
    end

    logic [31:0] w_idx_wide;
    assign w_idx_wide = 32'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_pairs <= r_pairs;
            if (r_count == '0) begin
                r_o_rank   <= '0;
                r_o_entry  <= 1'b0;
                r_o_first  <= '0;
                r_o_second <= '0;
                r_o_score  <= '0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_rank   <= w_idx_wide[RANK_W-1:0];
                r_o_entry  <= 1'b1;
                r_o_first  <= w_first[r_rd_idx];
                r_o_second <= w_second[r_rd_idx];
                r_o_score  <= w_score[r_rd_idx];
                r_o_last   <= w_rd_last;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_tvalid;
    assign o_m_axis_tdata  = OUT_W'({r_o_pairs, r_o_score, r_o_second, r_o_first, r_o_rank});
    assign o_m_axis_tuser  = r_o_entry;
    assign o_m_axis_tlast  = r_o_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("held count beyond table depth");

    a_read_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> $stable(r_count) && $stable(r_pairs))
        else $error("table changed during readout");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) && (r_count != '0) |-> (CNT_W'(r_rd_idx) < w_out_n))
        else $error("readout walked past held entries");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_tvalid && !r_o_entry |-> r_o_last)
        else $error("empty-table result not marked last");

endmodule
